// ===== hdl/ultrasonic_echo_ranger_average_macros.svh =====
// ----------------------------------------------------------------------------
// ultrasonic echo ranger assertion macros
// shared concurrent assertion forms for the ranger modules
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_AVERAGE_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_AVERAGE_MACROS_SVH

// same-cycle implication
`define UERA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UERA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/uera_pkg.sv =====
// ----------------------------------------------------------------------------
// uera_pkg
// types and constants shared by the echo ranger controller and datapath
// ----------------------------------------------------------------------------
package uera_pkg;

    localparam int SAMPLE_DEPTH_DEF = 8;

    localparam int DATA_W     = 18;
    localparam int TICK_W     = 16;
    localparam int MUL_W      = 13;
    localparam int PROD_W     = TICK_W + MUL_W;
    localparam int DIST_SHIFT = 10;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 40;
    localparam int CFG_ADDR_W = 2;

    localparam logic [MUL_W-1:0]  DIST_MUL   = 13'd4496;
    localparam logic [TICK_W-1:0] TRIG_TICKS = 16'd3;

    localparam logic [DATA_W-1:0] MOUNT_HEIGHT_RST = 18'd51200;
    localparam logic [TICK_W-1:0] ECHO_TIMEOUT_RST = 16'd30000;
    localparam logic [DATA_W-1:0] MIN_DISTANCE_RST = 18'd128;
    localparam logic [DATA_W-1:0] MAX_DISTANCE_RST = 18'd153600;

    localparam logic [CFG_ADDR_W-1:0] REG_MOUNT_HEIGHT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ECHO_TIMEOUT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DISTANCE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DISTANCE = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_EVAL      = 3'd1,
        S_STORE     = 3'd2,
        S_DIV_START = 3'd3,
        S_DIV       = 3'd4,
        S_AVG       = 3'd5,
        S_OUT       = 3'd6
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic eval;
        logic store;
        logic div_start;
        logic avg;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/uera_div.sv =====
// ----------------------------------------------------------------------------
// uera_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module uera_div #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  last,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;

    assign last     = busy_reg && (step_reg == STEP_W'(DIVIDEND_W - 1));
    assign quotient = quo_reg;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            step_next = step_reg + STEP_W'(1);
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            if (last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

// ===== hdl/uera_dp.sv =====
// ----------------------------------------------------------------------------
// uera_dp
// echo ranger datapath: phase timing, distance, sample ring, mean, output word
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_average_macros.svh"

module uera_dp #(
    parameter int SAMPLE_DEPTH = uera_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [uera_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                cfg_wr_en,
    input  logic [uera_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [uera_pkg::DATA_W-1:0]         cfg_wr_data,
    input  uera_pkg::cmd_t                      cmd,
    output uera_pkg::status_t                   status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [uera_pkg::M_DATA_W-1:0]       m_tdata
);
    import uera_pkg::*;

    localparam int SLOT_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int SUM_W  = DATA_W + $clog2(SAMPLE_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(SAMPLE_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLE_DEPTH - 1);

    logic [DATA_W-1:0] mount_reg, min_reg, max_reg;
    logic [TICK_W-1:0] timeout_reg;

    logic              start_reg, echo_reg;
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next, ticks_inc;
    logic              trig_reg, done_reg, tmo_reg, cand_reg;
    logic              trig_c, done_c, tmo_c, cand_c;
    logic [PROD_W-1:0] prod_reg;

    logic [DATA_W-1:0] mem [SAMPLE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg, sum_upd;
    logic [DATA_W-1:0] avg_reg;

    logic [DATA_W:0]   dist_raw;
    logic [DATA_W-1:0] dist_sat, old_val;
    logic              store_ok;

    logic              have_avg;
    logic [DATA_W-1:0] avg_out, level;
    logic              m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic              div_last;
    logic [SUM_W-1:0]  quotient;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mount_reg   <= MOUNT_HEIGHT_RST;
            timeout_reg <= ECHO_TIMEOUT_RST;
            min_reg     <= MIN_DISTANCE_RST;
            max_reg     <= MAX_DISTANCE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MOUNT_HEIGHT: mount_reg   <= cfg_wr_data;
                REG_ECHO_TIMEOUT: timeout_reg <= cfg_wr_data[TICK_W-1:0];
                REG_MIN_DISTANCE: min_reg     <= cfg_wr_data;
                REG_MAX_DISTANCE: max_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            start_reg <= s_tdata[0];
            echo_reg  <= s_tdata[1];
        end
    end

    // phase step for one tick
    always_comb begin
        ticks_inc  = ticks_reg + TICK_W'(1);
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        trig_c     = 1'b0;
        done_c     = 1'b0;
        tmo_c      = 1'b0;
        cand_c     = 1'b0;
        case (phase_reg)
            PH_TRIG_LOW: begin
                ticks_next = ticks_inc;
                if (ticks_inc >= TRIG_TICKS) begin
                    phase_next = PH_TRIG_HIGH;
                    ticks_next = '0;
                end
            end
            PH_TRIG_HIGH: begin
                trig_c     = 1'b1;
                ticks_next = ticks_inc;
                if (ticks_inc >= TRIG_TICKS) begin
                    phase_next = PH_WAIT_RISE;
                    ticks_next = '0;
                end
            end
            PH_WAIT_RISE: begin
                if (echo_reg) begin
                    phase_next = PH_MEASURE;
                    ticks_next = TICK_W'(1);
                end else if (ticks_reg >= timeout_reg) begin
                    done_c = 1'b1;
                    tmo_c  = 1'b1;
                end else begin
                    ticks_next = ticks_inc;
                end
            end
            PH_MEASURE: begin
                if (!echo_reg) begin
                    done_c = 1'b1;
                    cand_c = 1'b1;
                end else if (ticks_reg >= timeout_reg) begin
                    done_c = 1'b1;
                    tmo_c  = 1'b1;
                end else begin
                    ticks_next = ticks_inc;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (start_reg) begin
                    phase_next = PH_TRIG_LOW;
                    ticks_next = '0;
                end
            end
        endcase
        if (done_c) begin
            phase_next = PH_IDLE;
            ticks_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ticks_reg <= '0;
            trig_reg  <= 1'b0;
            done_reg  <= 1'b0;
            tmo_reg   <= 1'b0;
            cand_reg  <= 1'b0;
        end else if (cmd.eval) begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            trig_reg  <= trig_c;
            done_reg  <= done_c;
            tmo_reg   <= tmo_c;
            cand_reg  <= cand_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            prod_reg <= PROD_W'(ticks_reg) * PROD_W'(DIST_MUL);
        end
    end

    // distance, window test and ring update
    always_comb begin
        dist_raw = prod_reg[PROD_W-1:DIST_SHIFT];
        dist_sat = dist_raw[DATA_W] ? '1 : dist_raw[DATA_W-1:0];
        store_ok = cand_reg && (dist_sat > min_reg) && (dist_sat < max_reg);
        old_val  = (count_reg == DEPTH_C) ? rd_data_reg : '0;
        sum_upd  = sum_reg - SUM_W'(old_val) + SUM_W'(dist_sat);
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[slot_reg];
        if (cmd.store && store_ok) begin
            mem[slot_reg] <= dist_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (cmd.store && store_ok) begin
            slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
            if (count_reg != DEPTH_C) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            sum_reg <= sum_upd;
        end
    end

    uera_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .last     (div_last),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg <= '0;
        end else if (cmd.avg) begin
            avg_reg <= (count_reg == '0) ? '0 : quotient[DATA_W-1:0];
        end
    end

    // output word
    always_comb begin
        have_avg = (count_reg != '0);
        avg_out  = have_avg ? avg_reg : '0;
        level    = (have_avg && (mount_reg > avg_reg)) ? mount_reg - avg_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {level, avg_out, have_avg, tmo_reg, done_reg, trig_reg};
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;
    assign status.done     = done_reg;
    assign status.div_last = div_last;
    assign status.out_free = !m_valid_reg || m_tready;

    `UERA_ASSERT_SAME(a_tmo_with_done, aclk, aresetn, tmo_reg, done_reg, "timeout without done")
    `UERA_ASSERT_NEXT(a_load_valid, aclk, aresetn, cmd.out_load, m_valid_reg, "word lost")
    `UERA_ASSERT_NEXT(a_echo_fall, aclk, aresetn, cmd.eval && (phase_reg == PH_MEASURE) && !echo_reg, cand_reg && done_reg, "echo fall missed")
    `UERA_ASSERT_NEXT(a_count_held, aclk, aresetn, count_reg != '0, count_reg != '0, "sample count dropped")

endmodule

// ===== hdl/uera_ctrl.sv =====
// ----------------------------------------------------------------------------
// uera_ctrl
// echo ranger sequencer: steps each input word through the datapath
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_average_macros.svh"

module uera_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  uera_pkg::status_t  status,
    output uera_pkg::cmd_t     cmd
);
    import uera_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_STORE;
            end
            S_STORE: begin
                cmd.store  = 1'b1;
                state_next = status.done ? S_DIV_START : S_OUT;
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (status.div_last) begin
                    state_next = S_AVG;
                end
            end
            S_AVG: begin
                cmd.avg    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `UERA_ASSERT_NEXT(a_accept_eval, aclk, aresetn, (state_reg == S_IDLE) && s_tvalid, state_reg == S_EVAL, "accepted word not evaluated")

endmodule

// ===== hdl/ultrasonic_echo_ranger_average.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_average
// ultrasonic ranging with trigger sequencing, echo timing and a moving mean
//
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: start_req, echo
// m_        out  m_tvalid/m_tready    m_tdata: trigger .. water_level
// cfg_      in   cfg_wr_en            cfg_addr, cfg_wr_data
//
// an accepted word passes S_EVAL and S_STORE and is loaded into the output
// register in S_OUT once it is free; a word that ends a measurement also
// passes S_DIV_START, S_DIV and S_AVG, the divider forming the mean one
// quotient bit per cycle; the input is taken again in the cycle after the load
// a finished word waits in the output register while the next word is taken
// reset is synchronous and needs no clearing pass
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_average #(
    parameter int SAMPLE_DEPTH = uera_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [uera_pkg::S_DATA_W-1:0]     s_tdata,     // start_req, echo
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // trigger, done_res, timed_out, have_average, average_distance, water_level
    output logic [uera_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [uera_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [uera_pkg::DATA_W-1:0]       cfg_wr_data
);
    import uera_pkg::*;

    cmd_t    cmd;
    status_t status;

    uera_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    uera_dp #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
